@@ rtl/pgwalk_pkg.sv @@
`timescale 1ns / 1ps
// shared types, codes and constants of the four-level page table walker
// no dependencies

package pgwalk_pkg;

    localparam int ADDR_W      = 52;
    localparam int VADDR_W     = 48;
    localparam int ENTRY_W     = 64;
    localparam int IDX_W       = 9;
    localparam int IN_TDATA_W  = 168;
    localparam int OUT_TDATA_W = 112;

    localparam int PRESENT_BIT = 0;
    localparam int LARGE_BIT   = 7;

    typedef logic [ADDR_W-1:0]  paddr_t;
    typedef logic [VADDR_W-1:0] vaddr_t;
    typedef logic [ENTRY_W-1:0] entry_t;
    typedef logic [IDX_W-1:0]   index_t;
    typedef logic [1:0]         level_t;

    localparam level_t LEVEL_TOP  = 2'd0;
    localparam level_t LEVEL_GIGA = 2'd1;
    localparam level_t LEVEL_MEGA = 2'd2;
    localparam level_t LEVEL_LEAF = 2'd3;

    localparam paddr_t BASE_MASK = ~paddr_t'(4'hF);
    localparam paddr_t MEGA_OFFS = paddr_t'(21'h1FFFFF);

    typedef enum logic {
        REQ_TRANSLATE = 1'b0,
        REQ_RESPONSE  = 1'b1
    } req_kind_t;

    typedef enum logic {
        RES_READ = 1'b0,
        RES_DONE = 1'b1
    } res_kind_t;

    typedef struct packed {
        req_kind_t req_type;
        paddr_t    table_base;
        vaddr_t    virt_addr;
        entry_t    mem_data;
    } walk_item_t;

    typedef struct packed {
        res_kind_t res_type;
        paddr_t    read_addr;
        paddr_t    phys_addr;
        logic      fault;
    } walk_res_t;

    function automatic index_t vaddr_index(input vaddr_t va, input level_t level);
        index_t idx;
        unique case (level)
            LEVEL_TOP:  idx = va[47:39];
            LEVEL_GIGA: idx = va[38:30];
            LEVEL_MEGA: idx = va[29:21];
            LEVEL_LEAF: idx = va[20:12];
            default:    idx = va[47:39];
        endcase
        return idx;
    endfunction

endpackage

@@ rtl/pgwalk_in_stage.sv @@
`timescale 1ns / 1ps
// input register stage of the page table walker
// depends on pgwalk_pkg

module pgwalk_in_stage import pgwalk_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  walk_item_t item_in,
    input  logic       take,
    output logic       item_valid,
    output walk_item_t item_out
);

    logic       valid_reg;
    walk_item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item_out   = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_in;
        end
    end

endmodule

@@ rtl/pgwalk_core.sv @@
`timescale 1ns / 1ps
// walk state and single-pass step logic: request, entry check, next read
// depends on pgwalk_pkg

module pgwalk_core import pgwalk_pkg::*; #(
    parameter int PHYS_FRAME_BITS = 36
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       take,
    input  walk_item_t item,
    output logic       res_valid,
    output walk_res_t  res
);

    localparam paddr_t FRAME_MASK =
        paddr_t'((53'(1) << PHYS_FRAME_BITS) - 53'(1)) & ~paddr_t'(12'hFFF);

    level_t level_reg, level_next;
    logic   busy_reg, busy_next;
    vaddr_t vaddr_reg, vaddr_next;
    paddr_t frame;

    assign frame = item.mem_data[ADDR_W-1:0] & FRAME_MASK;

    always_comb begin
        res_valid      = 1'b0;
        res.res_type   = RES_READ;
        res.read_addr  = '0;
        res.phys_addr  = '0;
        res.fault      = 1'b0;
        level_next     = level_reg;
        busy_next      = busy_reg;
        vaddr_next     = vaddr_reg;
        priority if (item.req_type == REQ_TRANSLATE) begin
            res_valid     = 1'b1;
            vaddr_next    = item.virt_addr;
            level_next    = LEVEL_TOP;
            busy_next     = 1'b1;
            res.read_addr = (item.table_base & BASE_MASK)
                          + {40'b0, vaddr_index(item.virt_addr, LEVEL_TOP), 3'b0};
        end else if (busy_reg) begin
            res_valid    = 1'b1;
            res.res_type = RES_DONE;
            busy_next    = 1'b0;
            level_next   = LEVEL_TOP;
            if (level_reg != LEVEL_LEAF) begin
                priority if (!item.mem_data[PRESENT_BIT]) begin
                    res.fault = 1'b1;
                end else if (level_reg == LEVEL_GIGA && item.mem_data[LARGE_BIT]) begin
                    res.phys_addr = {item.mem_data[51:30], vaddr_reg[29:0]};
                end else if (level_reg == LEVEL_MEGA && item.mem_data[LARGE_BIT]) begin
                    res.phys_addr = (frame & ~MEGA_OFFS) | {31'b0, vaddr_reg[20:0]};
                end else begin
                    res.res_type  = RES_READ;
                    busy_next     = 1'b1;
                    level_next    = level_reg + 2'd1;
                    res.read_addr = frame
                        + {40'b0, vaddr_index(vaddr_reg, level_reg + 2'd1), 3'b0};
                end
            end else if (frame == '0) begin
                res.fault = 1'b1;
            end else begin
                res.phys_addr = frame | {40'b0, vaddr_reg[11:0]};
            end
        end else begin
            // response with no walk active is dropped
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= LEVEL_TOP;
            busy_reg  <= 1'b0;
            vaddr_reg <= '0;
        end else if (take) begin
            level_reg <= level_next;
            busy_reg  <= busy_next;
            vaddr_reg <= vaddr_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_at_top: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> level_reg == LEVEL_TOP)
        else $error("idle walker not at top level");

    a_request_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        take && item.req_type == REQ_TRANSLATE |=> busy_reg && level_reg == LEVEL_TOP)
        else $error("request did not start a walk");

    a_leaf_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        take && item.req_type == REQ_RESPONSE && busy_reg && level_reg == LEVEL_LEAF
        |=> !busy_reg)
        else $error("leaf response did not end the walk");

    a_read_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.res_type == RES_READ |-> res.read_addr[2:0] == 3'b0)
        else $error("entry read address not 8-byte aligned");
`endif

endmodule

@@ rtl/pgwalk_out_stage.sv @@
`timescale 1ns / 1ps
// result register stage of the page table walker
// depends on pgwalk_pkg

module pgwalk_out_stage import pgwalk_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  walk_res_t res_in,
    output logic      can_load,
    output logic      m_tvalid,
    input  logic      m_tready,
    output walk_res_t res_out
);

    logic      valid_reg;
    walk_res_t res_reg;

    assign can_load = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign res_out  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

endmodule

@@ rtl/four_level_page_table_walker_top.sv @@
`timescale 1ns / 1ps
// four-level page table walker, top level: input register, step logic, result register
// a word accepted on s_ goes through the input register and the result register to m_
// throughput: one word per cycle on both sides unless m_ stalls (single-pass step logic)
// a response that arrives while no walk is active is consumed without a result word
// reset (aresetn low, synchronous) clears both stage valids and the walk state
// depends on pgwalk_pkg, pgwalk_in_stage, pgwalk_core, pgwalk_out_stage

module four_level_page_table_walker_top import pgwalk_pkg::*; #(
    parameter int PHYS_FRAME_BITS = 36
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // table_base, virt_addr, mem_data, zero pad
    input  logic                   s_tuser,   // req_type
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // read_addr, phys_addr, fault, zero pad
    output logic                   m_tuser    // res_type
);

    walk_item_t item_in, item;
    walk_res_t  res, res_out;
    logic       item_valid, res_valid, can_load, take;

    assign item_in.req_type   = req_kind_t'(s_tuser);
    assign item_in.table_base = s_tdata[51:0];
    assign item_in.virt_addr  = s_tdata[99:52];
    assign item_in.mem_data   = s_tdata[163:100];

    assign take = item_valid && can_load;

    pgwalk_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .item_in    (item_in),
        .take       (take),
        .item_valid (item_valid),
        .item_out   (item)
    );

    pgwalk_core #(
        .PHYS_FRAME_BITS (PHYS_FRAME_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    pgwalk_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (take && res_valid),
        .res_in   (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .res_out  (res_out)
    );

    assign m_tuser = res_out.res_type;
    assign m_tdata = {7'b0, res_out.fault, res_out.phys_addr, res_out.read_addr};

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the four-level page table walker: directed and random walks
// depends on pgwalk_pkg and four_level_page_table_walker_top

module testbench;
    import pgwalk_pkg::*;

    localparam int     PFB        = 36;
    localparam int     N_WORDS    = 800;
    localparam int     IDLE_LIMIT = 2000;
    localparam paddr_t FRAME_MASK = ((paddr_t'(1) << PFB) - 1) & ~paddr_t'(12'hFFF);
    localparam paddr_t GIGA_FRAME = paddr_t'({22{1'b1}}) << 30;

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;

    walk_item_t pending_words[$];
    walk_res_t  expected_words[$];

    // walker state as predicted
    level_t walk_lvl    = LEVEL_TOP;
    bit     walk_active = 1'b0;
    vaddr_t walk_va     = '0;

    int         err_cnt     = 0;
    int         gap_left    = 0;
    int         stall_left  = 0;
    int         idle_cycles = 0;
    bit         tail_phase  = 1'b0;
    int         n_words     = 0;
    walk_item_t next_word;
    walk_item_t took_word;
    walk_res_t  res_word;
    walk_res_t  want_word;

    four_level_page_table_walker_top #(
        .PHYS_FRAME_BITS(PFB)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic paddr_t entry_offset(input vaddr_t va, input level_t lvl);
        logic [8:0] idx;
        idx = 9'((va >> (39 - 9 * int'(lvl))) & 48'h1FF);
        return paddr_t'(idx) << 3;
    endfunction

    // advances the predicted walk by one word, returns 1 when a result word follows
    function automatic bit step_walker(input walk_item_t w, output walk_res_t r);
        paddr_t frame;
        r = '0;
        r.res_type = RES_READ;
        if (w.req_type == REQ_TRANSLATE) begin
            walk_va     = w.virt_addr;
            walk_lvl    = LEVEL_TOP;
            walk_active = 1'b1;
            r.read_addr = (w.table_base & BASE_MASK) + entry_offset(walk_va, LEVEL_TOP);
            return 1'b1;
        end
        if (!walk_active)
            return 1'b0;
        frame = paddr_t'(w.mem_data) & FRAME_MASK;
        if (walk_lvl == LEVEL_LEAF) begin
            if (frame == '0)
                r.fault = 1'b1;
            else
                r.phys_addr = frame + paddr_t'(walk_va[11:0]);
        end else if (!w.mem_data[PRESENT_BIT]) begin
            r.fault = 1'b1;
        end else if (walk_lvl == LEVEL_GIGA && w.mem_data[LARGE_BIT]) begin
            r.phys_addr = (paddr_t'(w.mem_data) & GIGA_FRAME) + paddr_t'(walk_va[29:0]);
        end else if (walk_lvl == LEVEL_MEGA && w.mem_data[LARGE_BIT]) begin
            r.phys_addr = (frame & ~MEGA_OFFS) + paddr_t'(walk_va[20:0]);
        end else begin
            walk_lvl    = walk_lvl + 2'd1;
            r.read_addr = frame + entry_offset(walk_va, walk_lvl);
            return 1'b1;
        end
        walk_active = 1'b0;
        walk_lvl    = LEVEL_TOP;
        r.res_type  = RES_DONE;
        return 1'b1;
    endfunction

    function automatic entry_t rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic push_word(input req_kind_t k, input paddr_t b, input vaddr_t v,
                             input entry_t d);
        walk_item_t w;
        w.req_type   = k;
        w.table_base = b;
        w.virt_addr  = v;
        w.mem_data   = d;
        pending_words.push_back(w);
    endtask

    task automatic push_request();
        push_word(REQ_TRANSLATE, paddr_t'(rand64()), vaddr_t'(rand64()), rand64());
    endtask

    task automatic push_entry(input entry_t d);
        push_word(REQ_RESPONSE, paddr_t'(rand64()), vaddr_t'(rand64()), d);
    endtask

    // one random walk, mostly well formed; returns the number of words that count
    task automatic push_random_walk(output int counted);
        entry_t e;
        bit     ended;
        ended   = 1'b0;
        counted = 1;
        push_request();
        for (int lvl = 0; lvl < 4 && !ended; lvl++) begin
            if ($urandom_range(0, 19) == 0)
                break;
            e = rand64();
            if (lvl == LEVEL_LEAF) begin
                if ($urandom_range(0, 9) == 0)
                    e = e & ~entry_t'(FRAME_MASK);
                ended = 1'b1;
            end else begin
                e[PRESENT_BIT] = ($urandom_range(0, 99) < 88);
                if (lvl != LEVEL_TOP)
                    e[LARGE_BIT] = ($urandom_range(0, 3) == 0);
                ended = !e[PRESENT_BIT] || (lvl != LEVEL_TOP && e[LARGE_BIT]);
            end
            push_entry(e);
            counted++;
        end
        // stray response after a finished walk
        if (ended && $urandom_range(0, 19) == 0)
            push_entry(rand64());
    endtask

    initial begin
        int got;
        // response with no walk active
        push_entry('1);
        // top entry address wraps, top entry not present
        push_word(REQ_TRANSLATE, '1, '1, '1);
        push_entry(~entry_t'(1));
        // second level not present
        push_word(REQ_TRANSLATE, '0, '0, '0);
        push_entry(entry_t'(1));
        push_entry('0);
        // 1 gb page
        push_request();
        push_entry('1);
        push_entry('1);
        // 2 mb page
        push_word(REQ_TRANSLATE, paddr_t'(rand64()), '1, '0);
        push_entry(entry_t'(1));
        push_entry(64'hFFFF_FFFF_FFFF_FF7F);
        push_entry('1);
        // leaf with zero frame
        push_request();
        push_entry(64'h0000_0000_0000_1001);
        push_entry(64'h0000_0000_0000_2001);
        push_entry(64'h0000_0000_0000_3001);
        push_entry(64'hFFFF_FFF0_0000_0FFF);
        // new request abandons the walk
        push_request();
        push_entry(64'hFFFF_FFFF_FFFF_FF7F);
        // leaf with present bit clear and nonzero frame
        push_word(REQ_TRANSLATE, '0, '1, '1);
        push_entry(64'hFFFF_FFFF_FFFF_FF7F);
        push_entry(64'hFFFF_FFFF_FFFF_FF7F);
        push_entry(64'hFFFF_FFFF_FFFF_FF7F);
        push_entry(64'h0000_000F_FFFF_F000);
        while (n_words < N_WORDS) begin
            push_random_walk(got);
            n_words += got;
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_words.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (expected_words.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (err_cnt == 0 && expected_words.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (pending_words.size() < 100)
                tail_phase <= 1'b1;
            if (s_tvalid && s_tready) begin
                took_word.req_type   = req_kind_t'(s_tuser);
                took_word.table_base = s_tdata[51:0];
                took_word.virt_addr  = s_tdata[99:52];
                took_word.mem_data   = s_tdata[163:100];
                if (step_walker(took_word, res_word))
                    expected_words.push_back(res_word);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    next_word = pending_words.pop_front();
                    s_tdata   <= {4'b0, next_word.mem_data, next_word.virt_addr,
                                  next_word.table_base};
                    s_tuser   <= next_word.req_type;
                    s_tvalid  <= 1'b1;
                    if (!tail_phase && $urandom_range(0, 7) == 0)
                        gap_left <= $urandom_range(1, 15);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected result word: tuser %0d, tdata %h", m_tuser, m_tdata);
                    err_cnt++;
                end else begin
                    want_word = expected_words.pop_front();
                    if (m_tuser != want_word.res_type) begin
                        $error("res_type mismatch: expected %0d, got %0d",
                               want_word.res_type, m_tuser);
                        err_cnt++;
                    end
                    if (m_tdata[51:0] != want_word.read_addr) begin
                        $error("read_addr mismatch: expected %h, got %h",
                               want_word.read_addr, m_tdata[51:0]);
                        err_cnt++;
                    end
                    if (m_tdata[103:52] != want_word.phys_addr) begin
                        $error("phys_addr mismatch: expected %h, got %h",
                               want_word.phys_addr, m_tdata[103:52]);
                        err_cnt++;
                    end
                    if (m_tdata[104] != want_word.fault) begin
                        $error("fault mismatch: expected %0d, got %0d",
                               want_word.fault, m_tdata[104]);
                        err_cnt++;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!tail_phase && $urandom_range(0, 5) == 0)
                    stall_left <= $urandom_range(1, 15);
            end
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("testbench failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
